@@ rtl/rph_pkg.sv @@
// ----------------------------------------------------------------------------
// rph_pkg
// Shared widths, codes and controller/datapath bundles for the polynomial
// rolling hash block.
// ----------------------------------------------------------------------------
package rph_pkg;

  // Storage and field widths
  localparam int MAX_LEN    = 1024;
  localparam int ADDR_W     = $clog2(MAX_LEN);
  localparam int LEN_W      = $clog2(MAX_LEN + 1);
  localparam int WORD_W     = 32;
  localparam int DWORD_W    = 2 * WORD_W;
  localparam int CHAR_W     = 8;
  localparam int CMD_W      = 2;
  localparam int ST_W       = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = WORD_W;
  localparam int RED_CNT_W  = $clog2(DWORD_W + 1);

  // Reduction lengths in bits
  localparam logic [RED_CNT_W-1:0] RED_SHORT = RED_CNT_W'(WORD_W);
  localparam logic [RED_CNT_W-1:0] RED_LONG  = RED_CNT_W'(DWORD_W);

  // Command codes
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD_CHAR  = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
  localparam logic [ST_W-1:0] ST_BAD_RANGE = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOD  = 1'd1;

  localparam logic [WORD_W-1:0] BASE_RESET = 32'd26;
  localparam logic [WORD_W-1:0] MOD_RESET  = 32'd1000000007;

  // Letters a..z map to digits 1..26
  localparam logic [CHAR_W-1:0] CHAR_LO   = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_HI   = 8'h7A;
  localparam logic [CHAR_W-1:0] CHAR_BIAS = 8'h60;

  // Operand fed to the reduction unit
  typedef enum logic [2:0] {
    SRC_PREF,
    SRC_POW,
    SRC_BASE,
    SRC_PROD,
    SRC_SUM
  } red_src_t;

  // Register that takes the remainder
  typedef enum logic [2:0] {
    DST_OPA,
    DST_OPB,
    DST_ACC,
    DST_HV,
    DST_PW,
    DST_WHOLE
  } red_dst_t;

  // Memory read address source
  typedef enum logic [1:0] {
    RD_TAIL,
    RD_RIGHT,
    RD_LEFT
  } rd_sel_t;

  typedef struct packed {
    logic              take;
    logic              rd_en;
    rd_sel_t           rd_sel;
    logic              red_start;
    red_src_t          red_src;
    red_dst_t          red_dst;
    logic              mul_en;
    logic              app_wr;
    logic              len_clr;
    logic              fin_query;
    logic              out_load;
    logic [ST_W-1:0]   out_status;
    logic              out_hv;
  } rph_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic              bad_char;
    logic              full;
    logic              bad_range;
    logic              red_done;
  } rph_stat_t;

endpackage

@@ rtl/rph_in_if.sv @@
// ----------------------------------------------------------------------------
// rph_in_if
// Input channel: one command word per handshake.
// ----------------------------------------------------------------------------
interface rph_in_if;
  import rph_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [CHAR_W-1:0]   char_byte;
  logic [ADDR_W-1:0]   left_index;
  logic [ADDR_W-1:0]   right_index;

  modport source (
    output valid, command, char_byte, left_index, right_index,
    input  ready
  );

  modport sink (
    input  valid, command, char_byte, left_index, right_index,
    output ready
  );
endinterface

@@ rtl/rph_out_if.sv @@
// ----------------------------------------------------------------------------
// rph_out_if
// Output channel: one result word per handshake.
// ----------------------------------------------------------------------------
interface rph_out_if;
  import rph_pkg::*;

  logic                valid;
  logic                ready;
  logic [WORD_W-1:0]   hash_value;
  logic [LEN_W-1:0]    string_length;
  logic [ST_W-1:0]     status;

  modport source (
    output valid, hash_value, string_length, status,
    input  ready
  );

  modport sink (
    input  valid, hash_value, string_length, status,
    output ready
  );
endinterface

@@ rtl/rph_mod.sv @@
// ----------------------------------------------------------------------------
// rph_mod
// Bit-serial restoring remainder unit: operand mod modulus, one bit a cycle.
// Done pulses after the last bit of a short (32-bit) or long (64-bit) operand.
// ----------------------------------------------------------------------------
module rph_mod (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         long_op,
  input  logic [rph_pkg::DWORD_W-1:0]  operand,
  input  logic [rph_pkg::WORD_W-1:0]   modulus,
  output logic                         done,
  output logic [rph_pkg::WORD_W-1:0]   rem
);
  import rph_pkg::*;

  logic                 busy;
  logic [RED_CNT_W-1:0] cnt;
  logic [DWORD_W-1:0]   shreg;
  logic [WORD_W:0]      trial;
  logic [WORD_W:0]      diff;
  logic [WORD_W-1:0]    rem_next;

  // Shift the next bit in and subtract when the partial remainder allows
  always_comb begin
    trial    = {rem, shreg[DWORD_W-1]};
    diff     = trial - {1'b0, modulus};
    rem_next = (trial >= {1'b0, modulus}) ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
  end

  // Control: count bits, pulse done after the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= long_op ? RED_LONG : RED_SHORT;
      end else if (busy) begin
        cnt <= cnt - RED_CNT_W'(1);
        if (cnt == RED_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: align short operands to the top, then iterate
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= long_op ? operand : {operand[WORD_W-1:0], {WORD_W{1'b0}}};
      rem   <= '0;
    end else if (busy) begin
      shreg <= {shreg[DWORD_W-2:0], 1'b0};
      rem   <= rem_next;
    end
  end

endmodule

@@ rtl/rph_dp.sv @@
// ----------------------------------------------------------------------------
// rph_dp
// Datapath: configuration registers, prefix-hash and power memories, string
// length, operand registers, multiplier and the shared remainder unit.
// ----------------------------------------------------------------------------
module rph_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  rph_pkg::rph_cmd_t              cmd,
  output rph_pkg::rph_stat_t             stat,
  input  logic                           cfg_we,
  input  logic [rph_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rph_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [rph_pkg::CMD_W-1:0]      in_command,
  input  logic [rph_pkg::CHAR_W-1:0]     in_char_byte,
  input  logic [rph_pkg::ADDR_W-1:0]     in_left_index,
  input  logic [rph_pkg::ADDR_W-1:0]     in_right_index,
  output logic [rph_pkg::WORD_W-1:0]     hash_value,
  output logic [rph_pkg::LEN_W-1:0]      string_length,
  output logic [rph_pkg::ST_W-1:0]       status
);
  import rph_pkg::*;

  // Configuration
  logic [WORD_W-1:0]  hash_base;
  logic [WORD_W-1:0]  hash_modulus;
  logic [WORD_W-1:0]  mod_eff;

  // Latched item
  logic [CMD_W-1:0]   cmd_q;
  logic [CHAR_W-1:0]  char_q;
  logic [ADDR_W-1:0]  left_q;
  logic [ADDR_W-1:0]  right_q;

  // String state
  logic [LEN_W-1:0]   len;
  logic [LEN_W-1:0]   len_dec;
  logic [WORD_W-1:0]  prefix_mem [MAX_LEN];
  logic [WORD_W-1:0]  power_mem  [MAX_LEN];
  logic [ADDR_W-1:0]  pref_addr;
  logic [ADDR_W-1:0]  pow_addr;
  logic [WORD_W-1:0]  pref_q;
  logic [WORD_W-1:0]  pow_q;
  logic               force_empty;
  logic [WORD_W-1:0]  pref_val;
  logic [WORD_W-1:0]  pow_val;

  // Arithmetic registers
  logic [WORD_W-1:0]  opa;
  logic [WORD_W-1:0]  opb;
  logic [DWORD_W-1:0] prod;
  logic [WORD_W-1:0]  acc;
  logic [WORD_W-1:0]  whole;
  logic [WORD_W-1:0]  hv_r;
  logic [WORD_W-1:0]  pw_r;

  logic [CHAR_W-1:0]  digit;
  logic [WORD_W:0]    sum_digit;
  logic [WORD_W:0]    q_diff;
  logic [WORD_W:0]    q_red;
  logic [WORD_W-1:0]  q_hash;

  logic               red_long;
  logic [DWORD_W-1:0] red_operand;
  logic               red_done;
  logic [WORD_W-1:0]  red_rem;

  assign mod_eff = (hash_modulus == '0) ? WORD_W'(1) : hash_modulus;
  assign len_dec = len - LEN_W'(1);
  assign digit   = char_q - CHAR_BIAS;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_base    <= BASE_RESET;
      hash_modulus <= MOD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE: hash_base    <= cfg_data;
        REG_MOD:  hash_modulus <= cfg_data;
        default:  ;
      endcase
    end
  end

  // Capture the accepted word
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cmd_q   <= in_command;
      char_q  <= in_char_byte;
      left_q  <= in_left_index;
      right_q <= in_right_index;
    end
  end

  // Stored length
  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
    end else if (cmd.len_clr) begin
      len <= '0;
    end else if (cmd.app_wr) begin
      len <= len + LEN_W'(1);
    end
  end

  // Memory read addresses
  always_comb begin
    unique case (cmd.rd_sel)
      RD_TAIL: begin
        pref_addr = len_dec[ADDR_W-1:0];
        pow_addr  = len_dec[ADDR_W-1:0];
      end
      RD_RIGHT: begin
        pref_addr = right_q;
        pow_addr  = right_q - left_q;
      end
      RD_LEFT: begin
        pref_addr = left_q - ADDR_W'(1);
        pow_addr  = right_q - left_q;
      end
      default: begin
        pref_addr = right_q;
        pow_addr  = right_q - left_q;
      end
    endcase
  end

  // Prefix-hash memory
  always_ff @(posedge clk) begin
    if (cmd.app_wr) begin
      prefix_mem[len[ADDR_W-1:0]] <= hv_r;
    end
    if (cmd.rd_en) begin
      pref_q <= prefix_mem[pref_addr];
    end
  end

  // Power memory
  always_ff @(posedge clk) begin
    if (cmd.app_wr) begin
      power_mem[len[ADDR_W-1:0]] <= pw_r;
    end
    if (cmd.rd_en) begin
      pow_q <= power_mem[pow_addr];
    end
  end

  // Empty string or prefix before position zero reads as hash 0, power 1
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      force_empty <= ((cmd.rd_sel == RD_TAIL) && (len == '0)) ||
                     ((cmd.rd_sel == RD_LEFT) && (left_q == '0));
    end
  end

  assign pref_val = force_empty ? '0 : pref_q;
  assign pow_val  = force_empty ? WORD_W'(1) : pow_q;

  // Remainder unit operand select
  assign sum_digit = {1'b0, acc} + (WORD_W + 1)'(digit);

  always_comb begin
    unique case (cmd.red_src)
      SRC_PREF: red_operand = DWORD_W'(pref_val);
      SRC_POW:  red_operand = DWORD_W'(pow_val);
      SRC_BASE: red_operand = DWORD_W'(hash_base);
      SRC_PROD: red_operand = prod;
      SRC_SUM:  red_operand = DWORD_W'(sum_digit);
      default:  red_operand = prod;
    endcase
  end

  assign red_long = (cmd.red_src == SRC_PROD) || (cmd.red_src == SRC_SUM);

  rph_mod u_mod (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.red_start),
    .long_op (red_long),
    .operand (red_operand),
    .modulus (mod_eff),
    .done    (red_done),
    .rem     (red_rem)
  );

  // Substring hash: whole + p - sub, folded once
  always_comb begin
    q_diff = {1'b0, whole} + {1'b0, mod_eff} - {1'b0, acc};
    q_red  = q_diff - {1'b0, mod_eff};
    q_hash = (q_diff >= {1'b0, mod_eff}) ? q_red[WORD_W-1:0] : q_diff[WORD_W-1:0];
  end

  // Multiply, write back remainders, finish queries
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= {{WORD_W{1'b0}}, opa} * {{WORD_W{1'b0}}, opb};
    end
    if (red_done) begin
      unique case (cmd.red_dst)
        DST_OPA:   opa   <= red_rem;
        DST_OPB:   opb   <= red_rem;
        DST_ACC:   acc   <= red_rem;
        DST_HV:    hv_r  <= red_rem;
        DST_PW:    pw_r  <= red_rem;
        DST_WHOLE: whole <= red_rem;
        default:   ;
      endcase
    end
    if (cmd.fin_query) begin
      hv_r <= q_hash;
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      hash_value    <= cmd.out_hv ? hv_r : '0;
      string_length <= len;
      status        <= cmd.out_status;
    end
  end

  // Status to the controller
  always_comb begin
    stat.cmd       = cmd_q;
    stat.bad_char  = (char_q < CHAR_LO) || (char_q > CHAR_HI);
    stat.full      = (len >= LEN_W'(MAX_LEN));
    stat.bad_range = (left_q > right_q) || (LEN_W'(right_q) >= len);
    stat.red_done  = red_done;
  end

endmodule

@@ rtl/rph_ctrl.sv @@
// ----------------------------------------------------------------------------
// rph_ctrl
// Controller: decodes each word, sequences reads, reductions and multiplies,
// and owns the handshakes of both channels.
// ----------------------------------------------------------------------------
module rph_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  rph_pkg::rph_stat_t  stat,
  output rph_pkg::rph_cmd_t   cmd
);
  import rph_pkg::*;

  typedef enum logic [20:0] {
    S_IDLE     = 21'h000001,
    S_DECODE   = 21'h000002,
    S_A_RD     = 21'h000004,
    S_A_RPREF  = 21'h000008,
    S_A_RBASE  = 21'h000010,
    S_A_MUL1   = 21'h000020,
    S_A_RPROD1 = 21'h000040,
    S_A_RSUM   = 21'h000080,
    S_A_RPOW   = 21'h000100,
    S_A_MUL2   = 21'h000200,
    S_A_RPROD2 = 21'h000400,
    S_A_WRITE  = 21'h000800,
    S_Q_RDR    = 21'h001000,
    S_Q_RWHOLE = 21'h002000,
    S_Q_RDL    = 21'h004000,
    S_Q_RPREF  = 21'h008000,
    S_Q_RPOW   = 21'h010000,
    S_Q_MUL    = 21'h020000,
    S_Q_RPROD  = 21'h040000,
    S_Q_FIN    = 21'h080000,
    S_OUT      = 21'h100000
  } state_t;

  state_t          state;
  state_t          state_next;
  logic [ST_W-1:0] st_r;
  logic [ST_W-1:0] st_r_next;
  logic            use_hv;
  logic            use_hv_next;
  logic            launched;
  logic            launched_next;

  assign in_ready = (state == S_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_next  = state;
    st_r_next   = st_r;
    use_hv_next = use_hv;
    cmd         = '0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_DECODE;
        end
      end

      // Check the word and pick a path
      S_DECODE: begin
        st_r_next   = ST_OK;
        use_hv_next = 1'b0;
        state_next  = S_OUT;
        if (stat.cmd == CMD_APPEND) begin
          if (stat.bad_char) begin
            st_r_next = ST_BAD_CHAR;
          end else if (stat.full) begin
            st_r_next = ST_FULL;
          end else begin
            use_hv_next = 1'b1;
            state_next  = S_A_RD;
          end
        end else if (stat.cmd == CMD_QUERY) begin
          if (stat.bad_range) begin
            st_r_next = ST_BAD_RANGE;
          end else begin
            use_hv_next = 1'b1;
            state_next  = S_Q_RDR;
          end
        end else if (stat.cmd == CMD_CLEAR) begin
          cmd.len_clr = 1'b1;
        end
      end

      // Append: new prefix = (prev*B + digit) mod p, new power = pow*B mod p
      S_A_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_TAIL;
        state_next = S_A_RPREF;
      end
      S_A_RPREF: begin
        cmd.red_start = !launched;
        cmd.red_src   = SRC_PREF;
        cmd.red_dst   = DST_OPA;
        if (stat.red_done) state_next = S_A_RBASE;
      end
      S_A_RBASE: begin
        cmd.red_start = !launched;
        cmd.red_src   = SRC_BASE;
        cmd.red_dst   = DST_OPB;
        if (stat.red_done) state_next = S_A_MUL1;
      end
      S_A_MUL1: begin
        cmd.mul_en = 1'b1;
        state_next = S_A_RPROD1;
      end
      S_A_RPROD1: begin
        cmd.red_start = !launched;
        cmd.red_src   = SRC_PROD;
        cmd.red_dst   = DST_ACC;
        if (stat.red_done) state_next = S_A_RSUM;
      end
      S_A_RSUM: begin
        cmd.red_start = !launched;
        cmd.red_src   = SRC_SUM;
        cmd.red_dst   = DST_HV;
        if (stat.red_done) state_next = S_A_RPOW;
      end
      S_A_RPOW: begin
        cmd.red_start = !launched;
        cmd.red_src   = SRC_POW;
        cmd.red_dst   = DST_OPA;
        if (stat.red_done) state_next = S_A_MUL2;
      end
      S_A_MUL2: begin
        cmd.mul_en = 1'b1;
        state_next = S_A_RPROD2;
      end
      S_A_RPROD2: begin
        cmd.red_start = !launched;
        cmd.red_src   = SRC_PROD;
        cmd.red_dst   = DST_PW;
        if (stat.red_done) state_next = S_A_WRITE;
      end
      S_A_WRITE: begin
        cmd.app_wr = 1'b1;
        state_next = S_OUT;
      end

      // Query: whole - prefix(left-1) * B^k, all mod p
      S_Q_RDR: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_RIGHT;
        state_next = S_Q_RWHOLE;
      end
      S_Q_RWHOLE: begin
        cmd.red_start = !launched;
        cmd.red_src   = SRC_PREF;
        cmd.red_dst   = DST_WHOLE;
        if (stat.red_done) state_next = S_Q_RDL;
      end
      S_Q_RDL: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_LEFT;
        state_next = S_Q_RPREF;
      end
      S_Q_RPREF: begin
        cmd.red_start = !launched;
        cmd.red_src   = SRC_PREF;
        cmd.red_dst   = DST_OPA;
        if (stat.red_done) state_next = S_Q_RPOW;
      end
      S_Q_RPOW: begin
        cmd.red_start = !launched;
        cmd.red_src   = SRC_POW;
        cmd.red_dst   = DST_OPB;
        if (stat.red_done) state_next = S_Q_MUL;
      end
      S_Q_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = S_Q_RPROD;
      end
      S_Q_RPROD: begin
        cmd.red_start = !launched;
        cmd.red_src   = SRC_PROD;
        cmd.red_dst   = DST_ACC;
        if (stat.red_done) state_next = S_Q_FIN;
      end
      S_Q_FIN: begin
        cmd.fin_query = 1'b1;
        state_next    = S_OUT;
      end

      // Hand the result to the output register once it is free
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = st_r;
          cmd.out_hv     = use_hv;
          state_next     = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  assign launched_next = stat.red_done ? 1'b0 : (launched | cmd.red_start);

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      st_r     <= ST_OK;
      use_hv   <= 1'b0;
      launched <= 1'b0;
    end else begin
      state    <= state_next;
      st_r     <= st_r_next;
      use_hv   <= use_hv_next;
      launched <= launched_next;
    end
  end

  // Output valid: set on load, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

@@ rtl/polynomial_rolling_hash_substring.sv @@
// ----------------------------------------------------------------------------
// polynomial_rolling_hash_substring
// Appends run three 32-bit and three 64-bit serial reductions, queries three
// 32-bit and one 64-bit; clear, the unused command and rejected words need
// none. One word in flight: a word is accepted only once the last result is
// loaded, and an unread result holds back the next one.
// Synchronous reset empties the string and loads base 26, modulus 1000000007.
// ----------------------------------------------------------------------------
module polynomial_rolling_hash_substring (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [rph_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rph_pkg::CFG_DATA_W-1:0] cfg_data,
  rph_in_if.sink                         in_ch,
  rph_out_if.source                      out_ch
);
  import rph_pkg::*;

  rph_cmd_t  cmd;
  rph_stat_t stat;

  rph_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rph_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_command     (in_ch.command),
    .in_char_byte   (in_ch.char_byte),
    .in_left_index  (in_ch.left_index),
    .in_right_index (in_ch.right_index),
    .hash_value     (out_ch.hash_value),
    .string_length  (out_ch.string_length),
    .status         (out_ch.status)
  );

endmodule

@@ tb/sv/polynomial_rolling_hash_substring_tb.sv @@
// ----------------------------------------------------------------------------
// polynomial_rolling_hash_substring_tb
// Self-checking bench for the rolling hash block. A built-in hash predictor
// tracks the prefix hashes, base powers and string length. Directed words
// cover letter extremes, rejected words and whole-string queries. Random
// phases then run at several base/modulus settings, extremes included, with
// bursty gaps on both channels. The run ends by filling the store to its
// limit with no gaps.
// ----------------------------------------------------------------------------
module polynomial_rolling_hash_substring_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rph_pkg::*;

  localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int TAIL_CYCLES    = 40;

  typedef struct packed {
    logic [WORD_W-1:0] hash_value;
    logic [LEN_W-1:0]  string_length;
    logic [ST_W-1:0]   status;
  } hash_word_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  rx_ready = 1'b0;
  bit                    gaps_on = 1'b1;
  int unsigned           stall_left = 0;
  int unsigned           idle_cycles = 0;
  int unsigned           error_count = 0;

  // Predictor state
  logic [WORD_W-1:0] base_q;
  logic [WORD_W-1:0] modulus_q;
  logic [LEN_W-1:0]  length_q;
  logic [WORD_W-1:0] prefix_q [MAX_LEN];
  logic [WORD_W-1:0] powers_q [MAX_LEN];

  hash_word_t expected_hashes [$];
  hash_word_t want;

  rph_in_if  in_ch ();
  rph_out_if out_ch ();

  polynomial_rolling_hash_substring u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  assign out_ch.ready = rx_ready;

  // Stall the result side in random bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      rx_ready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 29) == 0) begin
      stall_left = $urandom_range(0, 18);
      rx_ready <= 1'b0;
    end else begin
      rx_ready <= 1'b1;
    end
  end

  // Compare each result word with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_hashes.size() == 0) begin
        $error("unexpected result word: hash_value %0d string_length %0d status %0d",
               out_ch.hash_value, out_ch.string_length, out_ch.status);
        error_count++;
      end else begin
        want = expected_hashes.pop_front();
        if (out_ch.hash_value !== want.hash_value) begin
          $error("hash_value: expected %0d, got %0d", want.hash_value, out_ch.hash_value);
          error_count++;
        end
        if (out_ch.string_length !== want.string_length) begin
          $error("string_length: expected %0d, got %0d",
                 want.string_length, out_ch.string_length);
          error_count++;
        end
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_ch.status);
          error_count++;
        end
      end
    end
  end

  // End the run when no word moves for too long
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic logic [63:0] mod_mul(logic [63:0] a, logic [63:0] b, logic [63:0] p);
    return ((a % p) * (b % p)) % p;
  endfunction

  // Work out the result of one accepted word and advance the predictor
  function automatic hash_word_t predict_hash(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
                                              logic [ADDR_W-1:0] lft, logic [ADDR_W-1:0] rgt);
    hash_word_t  res;
    logic [63:0] p;
    logic [63:0] prev;
    logic [63:0] pw;
    logic [63:0] whole;
    logic [63:0] sub;
    logic [63:0] hv;
    res = '0;
    p = (modulus_q == '0) ? 64'd1 : {32'd0, modulus_q};
    unique case (cmd)
      CMD_APPEND: begin
        if (ch < CHAR_LO || ch > CHAR_HI) begin
          res.status = ST_BAD_CHAR;
        end else if (length_q >= MAX_LEN) begin
          res.status = ST_FULL;
        end else begin
          if (length_q != 0) begin
            prev = {32'd0, prefix_q[ADDR_W'(length_q - LEN_W'(1))]};
            pw = mod_mul({32'd0, powers_q[ADDR_W'(length_q - LEN_W'(1))]},
                         {32'd0, base_q}, p);
          end else begin
            prev = 64'd0;
            pw = {32'd0, base_q} % p;
          end
          hv = (mod_mul(prev, {32'd0, base_q}, p) + 64'(ch - CHAR_BIAS)) % p;
          prefix_q[length_q[ADDR_W-1:0]] = hv[WORD_W-1:0];
          powers_q[length_q[ADDR_W-1:0]] = pw[WORD_W-1:0];
          length_q++;
          res.hash_value = hv[WORD_W-1:0];
        end
      end
      CMD_QUERY: begin
        if (lft > rgt || rgt >= length_q) begin
          res.status = ST_BAD_RANGE;
        end else begin
          whole = {32'd0, prefix_q[rgt]} % p;
          sub = 64'd0;
          if (lft != 0) begin
            sub = mod_mul({32'd0, prefix_q[lft - ADDR_W'(1)]},
                          {32'd0, powers_q[rgt - lft]}, p);
          end
          hv = (whole + p - sub) % p;
          res.hash_value = hv[WORD_W-1:0];
        end
      end
      CMD_CLEAR: length_q = '0;
      default: ;
    endcase
    res.string_length = length_q;
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] random_letter();
    return CHAR_LO + CHAR_W'($urandom_range(0, 25));
  endfunction

  function automatic logic [CHAR_W-1:0] random_non_letter();
    if ($urandom_range(0, 1) == 0) begin
      return CHAR_W'($urandom_range(0, CHAR_LO - 1));
    end
    return CHAR_W'($urandom_range(CHAR_HI + 1, 255));
  endfunction

  // Present one word, hold it until accepted, then record its expectation
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                           input logic [ADDR_W-1:0] lft, input logic [ADDR_W-1:0] rgt);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.command     <= cmd;
    in_ch.char_byte   <= ch;
    in_ch.left_index  <= lft;
    in_ch.right_index <= rgt;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_hashes.push_back(predict_hash(cmd, ch, lft, rgt));
  endtask

  // Hold the sender until every expected result is back
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_hashes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_registers(input logic [WORD_W-1:0] base, input logic [WORD_W-1:0] modulus);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_BASE;
    cfg_data  <= base;
    @(posedge clk);
    base_q = base;
    cfg_index <= REG_MOD;
    cfg_data  <= modulus;
    @(posedge clk);
    modulus_q = modulus;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Letter extremes and queries over the whole string and its parts
  task automatic test_basic_hash();
    send_word(CMD_APPEND, CHAR_LO, ADDR_W'($urandom), ADDR_W'($urandom));
    send_word(CMD_APPEND, CHAR_HI, ADDR_W'($urandom), ADDR_W'($urandom));
    send_word(CMD_APPEND, 8'h6D, ADDR_W'($urandom), ADDR_W'($urandom));
    send_word(CMD_QUERY, CHAR_W'($urandom), 10'd0, 10'd2);
    send_word(CMD_QUERY, CHAR_W'($urandom), 10'd1, 10'd2);
    send_word(CMD_QUERY, CHAR_W'($urandom), 10'd2, 10'd2);
    send_word(CMD_QUERY, CHAR_W'($urandom), 10'd0, 10'd0);
  endtask

  // Bad letters, bad ranges, the unused command and clear
  task automatic test_rejected_words();
    send_word(CMD_APPEND, CHAR_LO - 8'd1, 10'd0, 10'd0);
    send_word(CMD_APPEND, CHAR_HI + 8'd1, 10'd0, 10'd0);
    send_word(CMD_APPEND, 8'h00, 10'd0, 10'd0);
    send_word(CMD_APPEND, 8'hFF, 10'd0, 10'd0);
    send_word(CMD_QUERY, CHAR_W'($urandom), 10'd2, 10'd1);
    send_word(CMD_QUERY, CHAR_W'($urandom), 10'd0, 10'd3);
    send_word(CMD_QUERY, CHAR_W'($urandom), 10'd1023, 10'd1023);
    send_word(CMD_RESERVED, random_letter(), ADDR_W'($urandom), ADDR_W'($urandom));
    send_word(CMD_CLEAR, random_letter(), ADDR_W'($urandom), ADDR_W'($urandom));
    send_word(CMD_QUERY, CHAR_W'($urandom), 10'd0, 10'd0);
    send_word(CMD_APPEND, random_letter(), ADDR_W'($urandom), ADDR_W'($urandom));
    send_word(CMD_QUERY, CHAR_W'($urandom), 10'd0, 10'd0);
  endtask

  // Mostly appends and in-range queries, with some noise mixed in
  task automatic run_random_phase(input int count);
    int                sel;
    logic [ADDR_W-1:0] rgt;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 50 || (sel < 80 && length_q == 0)) begin
        send_word(CMD_APPEND, random_letter(), ADDR_W'($urandom), ADDR_W'($urandom));
      end else if (sel < 80) begin
        rgt = ADDR_W'($urandom_range(0, length_q - 1));
        if ($urandom_range(0, 4) == 0) begin
          send_word(CMD_QUERY, CHAR_W'($urandom), '0, ADDR_W'(length_q - 1));
        end else begin
          send_word(CMD_QUERY, CHAR_W'($urandom), ADDR_W'($urandom_range(0, rgt)), rgt);
        end
      end else if (sel < 85) begin
        send_word(CMD_QUERY, CHAR_W'($urandom), ADDR_W'($urandom), ADDR_W'($urandom));
      end else if (sel < 90) begin
        send_word(CMD_APPEND, random_non_letter(), ADDR_W'($urandom), ADDR_W'($urandom));
      end else if (sel < 93) begin
        send_word(CMD_RESERVED, CHAR_W'($urandom), ADDR_W'($urandom), ADDR_W'($urandom));
      end else if (sel < 96) begin
        send_word(CMD_CLEAR, CHAR_W'($urandom), ADDR_W'($urandom), ADDR_W'($urandom));
      end else begin
        send_word(CMD_APPEND, CHAR_W'($urandom), ADDR_W'($urandom), ADDR_W'($urandom));
      end
    end
  endtask

  // Random phases across base and modulus extremes; no explicit clear between phases
  task automatic test_register_sweep();
    logic [WORD_W-1:0] modulus;
    run_random_phase(30);
    set_registers(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_random_phase(30);
    set_registers(32'd0, 32'd2);
    run_random_phase(25);
    set_registers(WORD_W'($urandom), 32'd0);
    run_random_phase(20);
    set_registers(32'd31, 32'd1);
    run_random_phase(20);
    modulus = WORD_W'($urandom);
    if (modulus < 2) modulus = 32'd2;
    set_registers(WORD_W'($urandom), modulus);
    run_random_phase(30);
    set_registers(32'd257, 32'd4294967291);
    run_random_phase(30);
  endtask

  // Fill the store to its limit, then probe the top end
  task automatic test_full_store();
    logic [ADDR_W-1:0] rgt;
    set_registers(BASE_RESET, MOD_RESET);
    send_word(CMD_CLEAR, CHAR_W'($urandom), ADDR_W'($urandom), ADDR_W'($urandom));
    for (int i = 0; i < MAX_LEN; i++) begin
      send_word(CMD_APPEND, random_letter(), ADDR_W'($urandom), ADDR_W'($urandom));
    end
    send_word(CMD_APPEND, random_letter(), ADDR_W'($urandom), ADDR_W'($urandom));
    send_word(CMD_APPEND, random_non_letter(), ADDR_W'($urandom), ADDR_W'($urandom));
    send_word(CMD_QUERY, CHAR_W'($urandom), 10'd0, 10'd1023);
    send_word(CMD_QUERY, CHAR_W'($urandom), 10'd1, 10'd1023);
    send_word(CMD_QUERY, CHAR_W'($urandom), 10'd1023, 10'd1023);
    send_word(CMD_QUERY, CHAR_W'($urandom), 10'd512, 10'd1023);
    for (int i = 0; i < 20; i++) begin
      rgt = ADDR_W'($urandom_range(768, 1023));
      send_word(CMD_QUERY, CHAR_W'($urandom), ADDR_W'($urandom_range(0, rgt)), rgt);
    end
    send_word(CMD_CLEAR, CHAR_W'($urandom), ADDR_W'($urandom), ADDR_W'($urandom));
    send_word(CMD_QUERY, CHAR_W'($urandom), 10'd0, 10'd0);
  endtask

  initial begin
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = REG_BASE;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.command     = CMD_APPEND;
    in_ch.char_byte   = '0;
    in_ch.left_index  = '0;
    in_ch.right_index = '0;
    base_q            = BASE_RESET;
    modulus_q         = MOD_RESET;
    length_q          = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_basic_hash();
    test_rejected_words();
    test_register_sweep();
    gaps_on = 1'b0;
    test_full_store();

    // Wait out the last results, then a short tail for stray words
    in_ch.valid <= 1'b0;
    while (expected_hashes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
